// File: sv/dscr_pkg.sv
// Package for the dual serial channel register block.
// Holds operation codes, status bit constants and the result record type.
// No dependencies.
package dscr_pkg;

  localparam int NUM_CHANNELS   = 2;
  localparam int FIFO_DEPTH_DEF = 128;

  // Operation codes of one input transfer.
  localparam logic [2:0] OP_RX_BYTE    = 3'd0;
  localparam logic [2:0] OP_DATA_READ  = 3'd1;
  localparam logic [2:0] OP_DATA_WRITE = 3'd2;
  localparam logic [2:0] OP_CTRL_READ  = 3'd3;
  localparam logic [2:0] OP_CTRL_WRITE = 3'd4;

  // Register 0 command field values.
  localparam logic [2:0] CMD_STATUS_RESET  = 3'd2;
  localparam logic [2:0] CMD_CHANNEL_RESET = 3'd3;
  localparam logic [2:0] CMD_TX_PEND_RESET = 3'd5;

  // Register pointer values that address stored registers.
  localparam logic [2:0] PTR_REG0 = 3'd0;
  localparam logic [2:0] PTR_REG1 = 3'd1;
  localparam logic [2:0] PTR_REG2 = 3'd2;

  // Status bits that never change (DCD and CTS).
  localparam logic [7:0] ST_FIXED    = 8'h28;
  localparam logic [7:0] WR1_TX_INT  = 8'h02;
  localparam logic [7:0] WR1_RX_MODE = 8'h18;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rd_mem;
    logic       tx_strobe;
    logic [7:0] tx_byte;
    logic       irq_strobe;
    logic [7:0] irq_vector;
    logic [2:0] irq_source;
    logic       rx_overflow;
  } dscr_res_t;

endpackage

// File: sv/dual_serial_channel_registers_core.sv
// Dual serial channel register block, top level.
// A result is registered in the memory-read stage, then in the output register.
// Throughput: one transfer per cycle if unstalled; memory read and write once a cycle.
// Reset: synchronous, active low; clears registers, status, FIFO pointers and valid flags.
// The receive memory is not cleared; only entries written since are ever read.
module dual_serial_channel_registers_core #(
  parameter int FIFO_DEPTH = dscr_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic       in_channel,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_tx_strobe,
  output logic [7:0] out_tx_byte,
  output logic       out_irq_strobe,
  output logic [7:0] out_irq_vector,
  output logic [2:0] out_irq_source,
  output logic       out_rx_overflow
);

  // Each channel owns half of the receive memory; the channel bit is the
  // top address bit above the FIFO pointer.
  localparam int PTR_W = $clog2(FIFO_DEPTH);

  logic                accept;
  logic                mem_we;
  logic                mem_re;
  logic [PTR_W:0]      mem_waddr;
  logic [PTR_W:0]      mem_raddr;
  logic [7:0]          mem_q;
  dscr_pkg::dscr_res_t res_c;
  dscr_pkg::dscr_res_t res_o;

  // All register and pointer state updates at the edge where a transfer is
  // accepted, so the next transfer always sees fully updated state. A data
  // read issues its memory read at that same edge; the data joins the result
  // one stage later.
  dscr_ctrl #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .op        (in_operation),
    .ch        (in_channel),
    .data      (in_byte_in),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res       (res_c)
  );

  // A write and a read never address the same live entry in one cycle: a
  // read only targets entries written at an earlier edge.
  dscr_fifo_mem #(
    .ADDR_W (PTR_W + 1)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (in_byte_in),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_q)
  );

  // The read stage and output register keep accepting while a finished
  // result waits, until both hold a transfer.
  dscr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accept    (accept),
    .res_in    (res_c),
    .mem_q     (mem_q),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_o)
  );

  assign out_read_data   = res_o.read_data;
  assign out_tx_strobe   = res_o.tx_strobe;
  assign out_tx_byte     = res_o.tx_byte;
  assign out_irq_strobe  = res_o.irq_strobe;
  assign out_irq_vector  = res_o.irq_vector;
  assign out_irq_source  = res_o.irq_source;
  assign out_rx_overflow = res_o.rx_overflow;

endmodule

// File: sv/dscr_fifo_mem.sv
// Receive data memory shared by both channels, one write and one read port.
// Read data is registered and holds until the next read.
// Depends on nothing but its parameter.
module dscr_fifo_mem #(
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/dscr_ctrl.sv
// Register, status and FIFO pointer state of both channels with the
// per-transfer decode. Depends on dscr_pkg; drives the receive memory.
module dscr_ctrl #(
  parameter int FIFO_DEPTH = dscr_pkg::FIFO_DEPTH_DEF,
  parameter int PTR_W      = $clog2(FIFO_DEPTH),
  parameter int CNT_W      = $clog2(FIFO_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          op,
  input  logic                ch,
  input  logic [7:0]          data,
  output logic                mem_we,
  output logic [PTR_W:0]      mem_waddr,
  output logic                mem_re,
  output logic [PTR_W:0]      mem_raddr,
  output dscr_pkg::dscr_res_t res
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  logic [7:0]       wr0_r  [2];
  logic [7:0]       wr0_nxt[2];
  logic [7:0]       wr1_r  [2];
  logic [7:0]       wr1_nxt[2];
  logic [7:0]       wr2_r, wr2_nxt;
  logic [1:0]       rxa_r, rxa_nxt;
  logic [1:0]       txe_r, txe_nxt;
  logic             int_r, int_nxt;
  logic [PTR_W-1:0] head_r [2];
  logic [PTR_W-1:0] head_nxt[2];
  logic [PTR_W-1:0] tail_r [2];
  logic [PTR_W-1:0] tail_nxt[2];
  logic [CNT_W-1:0] cnt_r  [2];
  logic [CNT_W-1:0] cnt_nxt[2];

  function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    logic [2:0] ptr;
    logic       do_check;
    logic       raise;

    wr0_nxt   = wr0_r;
    wr1_nxt   = wr1_r;
    wr2_nxt   = wr2_r;
    rxa_nxt   = rxa_r;
    txe_nxt   = txe_r;
    int_nxt   = int_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    res       = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {ch, tail_r[ch]};
    mem_raddr = {ch, head_r[ch]};
    ptr       = wr0_r[ch][2:0];
    do_check  = 1'b0;
    raise     = 1'b0;

    if (accept) begin
      case (op)
        dscr_pkg::OP_RX_BYTE: begin
          if (cnt_r[ch] != CNT_FULL) begin
            mem_we       = 1'b1;
            tail_nxt[ch] = next_pos(tail_r[ch]);
            cnt_nxt[ch]  = cnt_r[ch] + 1'b1;
          end else begin
            res.rx_overflow = 1'b1;
          end
          do_check = 1'b1;
        end
        dscr_pkg::OP_DATA_READ: begin
          int_nxt = 1'b0;
          if (cnt_r[ch] != '0) begin
            mem_re       = 1'b1;
            res.rd_mem   = 1'b1;
            head_nxt[ch] = next_pos(head_r[ch]);
            cnt_nxt[ch]  = cnt_r[ch] - 1'b1;
          end
          do_check = 1'b1;
        end
        dscr_pkg::OP_DATA_WRITE: begin
          res.tx_strobe = 1'b1;
          res.tx_byte   = data;
          txe_nxt[ch]   = 1'b1;
          if ((wr1_r[ch] & dscr_pkg::WR1_TX_INT) != '0) begin
            raise = 1'b1;
          end
        end
        dscr_pkg::OP_CTRL_READ: begin
          wr0_nxt[ch] = {wr0_r[ch][7:3], 3'b000};
          if (ptr == dscr_pkg::PTR_REG0) begin
            res.read_data = dscr_pkg::ST_FIXED |
                            {5'b00000, txe_r[ch], int_r & ~ch, rxa_r[ch]};
          end
        end
        dscr_pkg::OP_CTRL_WRITE: begin
          wr0_nxt[ch] = {wr0_r[ch][7:3], 3'b000};
          case (ptr)
            dscr_pkg::PTR_REG0: begin
              wr0_nxt[ch] = data;
              case (data[5:3])
                dscr_pkg::CMD_STATUS_RESET: begin
                  if (!ch) begin
                    int_nxt = 1'b0;
                  end
                  txe_nxt[ch] = 1'b1;
                end
                dscr_pkg::CMD_CHANNEL_RESET: begin
                  wr0_nxt[ch]  = '0;
                  wr1_nxt[ch]  = '0;
                  if (ch) begin
                    wr2_nxt = '0;
                  end else begin
                    int_nxt = 1'b0;
                  end
                  rxa_nxt[ch]  = 1'b0;
                  txe_nxt[ch]  = 1'b1;
                  head_nxt[ch] = '0;
                  tail_nxt[ch] = '0;
                  cnt_nxt[ch]  = '0;
                end
                dscr_pkg::CMD_TX_PEND_RESET: begin
                  int_nxt     = 1'b0;
                  txe_nxt[ch] = 1'b0;
                end
                default: ;
              endcase
            end
            dscr_pkg::PTR_REG1: wr1_nxt[ch] = data;
            dscr_pkg::PTR_REG2: begin
              if (ch) begin
                wr2_nxt = data;
              end
            end
            default: ;
          endcase
          do_check = 1'b1;
        end
        default: ;
      endcase

      // Receive check runs on the updated registers and FIFO count.
      if (do_check) begin
        if (cnt_nxt[ch] == '0) begin
          rxa_nxt[ch] = 1'b0;
        end else begin
          rxa_nxt[ch] = 1'b1;
          if ((wr1_nxt[ch] & dscr_pkg::WR1_RX_MODE) != '0 && !int_nxt) begin
            raise = 1'b1;
          end
        end
      end

      if (raise) begin
        int_nxt        = 1'b1;
        res.irq_strobe = 1'b1;
        res.irq_vector = wr2_nxt;
        res.irq_source = {2'b10, ch};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr0_r  <= '{default: '0};
      wr1_r  <= '{default: '0};
      wr2_r  <= '0;
      rxa_r  <= '0;
      txe_r  <= 2'b11;
      int_r  <= 1'b0;
      head_r <= '{default: '0};
      tail_r <= '{default: '0};
      cnt_r  <= '{default: '0};
    end else begin
      wr0_r  <= wr0_nxt;
      wr1_r  <= wr1_nxt;
      wr2_r  <= wr2_nxt;
      rxa_r  <= rxa_nxt;
      txe_r  <= txe_nxt;
      int_r  <= int_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: sv/dscr_out.sv
// Result pipeline: a memory-read stage followed by the output register.
// Depends on dscr_pkg; merges the registered memory data into read results.
module dscr_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                accept,
  input  dscr_pkg::dscr_res_t res_in,
  input  logic [7:0]          mem_q,
  output logic                out_valid,
  input  logic                out_stall,
  output dscr_pkg::dscr_res_t res_out
);

  logic                s1_valid_r;
  dscr_pkg::dscr_res_t s1_res_r;
  logic                out_valid_r;
  dscr_pkg::dscr_res_t out_res_r;
  dscr_pkg::dscr_res_t s1_merged;
  logic                s1_adv;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_merged = s1_res_r;
    if (s1_res_r.rd_mem) begin
      s1_merged.read_data = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res_in;
    end
    if (s1_adv) begin
      out_res_r <= s1_merged;
    end
  end

  assign out_valid = out_valid_r;
  assign res_out   = out_res_r;

endmodule

// File: bench/serial_regs_monitor.sv
`timescale 1ns / 100ps
// Scoreboard for the dual serial channel register block: keeps its own copy of
// the write registers, status and receive FIFOs, predicts each response in order
// and compares it field by field. Depends on dscr_pkg for codes and constants.
module serial_regs_monitor #(
  parameter int FIFO_DEPTH = dscr_pkg::FIFO_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic       in_channel,
  input  logic [7:0] in_byte_in,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_read_data,
  input  logic       out_tx_strobe,
  input  logic [7:0] out_tx_byte,
  input  logic       out_irq_strobe,
  input  logic [7:0] out_irq_vector,
  input  logic [2:0] out_irq_source,
  input  logic       out_rx_overflow,
  output int         error_count,
  output int         responses_outstanding
);
  import dscr_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  localparam logic [7:0] ST_RX_AVAIL = 8'h01;
  localparam logic [7:0] ST_INT_PEND = 8'h02;
  localparam logic [7:0] ST_TX_EMPTY = 8'h04;
  localparam logic [7:0] ST_POWER_ON = ST_FIXED | ST_TX_EMPTY;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_strobe;
    logic [7:0] tx_byte;
    logic       irq_strobe;
    logic [7:0] irq_vector;
    logic [2:0] irq_source;
    logic       rx_overflow;
  } serial_result_t;

  logic [7:0] wreg    [NUM_CHANNELS][8];
  logic [7:0] status  [NUM_CHANNELS];
  logic [7:0] rx_mem  [NUM_CHANNELS][FIFO_DEPTH];
  logic [PW-1:0] rx_rd [NUM_CHANNELS];
  logic [PW-1:0] rx_wr [NUM_CHANNELS];
  logic [PW:0]   rx_fill [NUM_CHANNELS];

  serial_result_t responses_due[$];

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function void clear_channel(input int ch);
    for (int r = 0; r < 8; r++) wreg[ch][r] = '0;
    status[ch]  = ST_POWER_ON;
    rx_rd[ch]   = '0;
    rx_wr[ch]   = '0;
    rx_fill[ch] = '0;
  endfunction

  // All requests report through channel 0's pending bit and channel 1's vector.
  function void raise_request(input int ch, inout serial_result_t r);
    status[0]    = status[0] | ST_INT_PEND;
    r.irq_strobe = 1'b1;
    r.irq_vector = wreg[1][2];
    r.irq_source = 3'(ch + 4);
  endfunction

  function void receive_check(input int ch, inout serial_result_t r);
    if (rx_fill[ch] == 0) begin
      status[ch] = status[ch] & ~ST_RX_AVAIL;
    end else begin
      status[ch] = status[ch] | ST_RX_AVAIL;
      if ((wreg[ch][1] & WR1_RX_MODE) != 0 && (status[0] & ST_INT_PEND) == 0) begin
        raise_request(ch, r);
      end
    end
  endfunction

  function serial_result_t serial_response(input logic [2:0] op, input logic chan,
                                           input logic [7:0] data);
    serial_result_t r;
    int ch;
    logic [2:0] ptr;
    r  = '0;
    ch = int'(chan);
    case (op)
      OP_RX_BYTE: begin
        if (rx_fill[ch] < FIFO_DEPTH) begin
          rx_mem[ch][rx_wr[ch]] = data;
          rx_wr[ch]   = next_slot(rx_wr[ch]);
          rx_fill[ch] = rx_fill[ch] + 1'b1;
        end else begin
          r.rx_overflow = 1'b1;
        end
        receive_check(ch, r);
      end
      OP_DATA_READ: begin
        status[0] = status[0] & ~ST_INT_PEND;
        if (rx_fill[ch] != 0) begin
          r.read_data = rx_mem[ch][rx_rd[ch]];
          rx_rd[ch]   = next_slot(rx_rd[ch]);
          rx_fill[ch] = rx_fill[ch] - 1'b1;
        end
        receive_check(ch, r);
      end
      OP_DATA_WRITE: begin
        r.tx_strobe = 1'b1;
        r.tx_byte   = data;
        status[ch]  = status[ch] | ST_TX_EMPTY;
        if ((wreg[ch][1] & WR1_TX_INT) != 0) raise_request(ch, r);
      end
      OP_CTRL_READ: begin
        ptr = wreg[ch][0][2:0];
        wreg[ch][0][2:0] = '0;
        r.read_data = (ptr == PTR_REG0) ? status[ch] : 8'h00;
      end
      OP_CTRL_WRITE: begin
        ptr = wreg[ch][0][2:0];
        wreg[ch][0][2:0] = '0;
        wreg[ch][ptr] = data;
        if (ptr == PTR_REG0) begin
          case (data[5:3])
            CMD_STATUS_RESET: begin
              if (ch == 0) status[0] = status[0] & ~ST_INT_PEND;
              status[ch] = status[ch] | ST_TX_EMPTY;
            end
            CMD_CHANNEL_RESET: clear_channel(ch);
            CMD_TX_PEND_RESET: begin
              status[0]  = status[0] & ~ST_INT_PEND;
              status[ch] = status[ch] & ~ST_TX_EMPTY;
            end
            default: ;
          endcase
        end
        receive_check(ch, r);
      end
      default: ;
    endcase
    return r;
  endfunction

  function void check_field(input string name, input logic [7:0] want, input logic [7:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h", $time, name, want, seen);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    serial_result_t want;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) clear_channel(c);
      responses_due.delete();
      error_count = 0;
    end else begin
      // Responses are checked before this edge's input is predicted; the block
      // cannot answer an access in the cycle it takes it.
      if (out_valid && !out_stall) begin
        if (responses_due.size() == 0) begin
          $display({"%0t: response with none expected: read 0x%02h tx %0b/0x%02h",
                    " irq %0b/0x%02h/%0d ovf %0b"},
                   $time, out_read_data, out_tx_strobe, out_tx_byte, out_irq_strobe,
                   out_irq_vector, out_irq_source, out_rx_overflow);
          error_count++;
        end else begin
          want = responses_due.pop_front();
          check_field("read_data", want.read_data, out_read_data);
          check_field("tx_strobe", 8'(want.tx_strobe), 8'(out_tx_strobe));
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("irq_strobe", 8'(want.irq_strobe), 8'(out_irq_strobe));
          check_field("irq_vector", want.irq_vector, out_irq_vector);
          check_field("irq_source", 8'(want.irq_source), 8'(out_irq_source));
          check_field("rx_overflow", 8'(want.rx_overflow), 8'(out_rx_overflow));
        end
      end
      if (in_valid && !in_stall) begin
        responses_due.push_back(serial_response(in_operation, in_channel, in_byte_in));
      end
    end
    responses_outstanding = responses_due.size();
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Top of the testbench for dual_serial_channel_registers_core: clock, reset,
// bus access stimulus and the verdict. Depends on dscr_pkg, the block and
// serial_regs_monitor, which predicts and checks every response.
module tb_top;
  import dscr_pkg::*;

  // The watchdog ends the run after this many cycles without any transfer.
  // The longest legal quiet stretch is the receiver hold-off below plus the
  // pipeline, so this is many times the slowest correct behavior.
  localparam int QUIET_LIMIT  = 1000;
  // Cycles to watch for stray responses once nothing more is expected.
  localparam int DRAIN_CYCLES = 10;
  // Length of the deliberate receiver hold-off that backs up the block.
  localparam int HOLD_CYCLES  = 60;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       in_valid        = 1'b0;
  logic [2:0] in_operation    = OP_RX_BYTE;
  logic       in_channel      = 1'b0;
  logic [7:0] in_byte_in      = 8'h00;
  logic       out_stall       = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_read_data;
  logic       out_tx_strobe;
  logic [7:0] out_tx_byte;
  logic       out_irq_strobe;
  logic [7:0] out_irq_vector;
  logic [2:0] out_irq_source;
  logic       out_rx_overflow;

  int error_count;
  int responses_outstanding;

  // Idle rates in percent, changed by the stimulus between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set by the stimulus to start one long receiver hold-off.
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_serial_channel_registers_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_channel      (in_channel),
    .in_byte_in      (in_byte_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_data   (out_read_data),
    .out_tx_strobe   (out_tx_strobe),
    .out_tx_byte     (out_tx_byte),
    .out_irq_strobe  (out_irq_strobe),
    .out_irq_vector  (out_irq_vector),
    .out_irq_source  (out_irq_source),
    .out_rx_overflow (out_rx_overflow)
  );

  serial_regs_monitor monitor (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_operation          (in_operation),
    .in_channel            (in_channel),
    .in_byte_in            (in_byte_in),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_read_data         (out_read_data),
    .out_tx_strobe         (out_tx_strobe),
    .out_tx_byte           (out_tx_byte),
    .out_irq_strobe        (out_irq_strobe),
    .out_irq_vector        (out_irq_vector),
    .out_irq_source        (out_irq_source),
    .out_rx_overflow       (out_rx_overflow),
    .error_count           (error_count),
    .responses_outstanding (responses_outstanding)
  );

  // Receiver side. Stall changes on the falling edge only. A requested
  // hold-off keeps stall high long enough that the block's pipeline fills
  // and it has to stall its own input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: any accepted transfer or delivered response counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** dual_serial_channel_registers_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one access and hold it until the block takes it. The task is
  // entered and left on a falling edge. Valid is lowered only for a random
  // gap, never between two back-to-back transfers, so each signal gets at
  // most one assignment per time step.
  task automatic send(input logic [2:0] op, input logic ch, input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_channel   <= ch;
    in_byte_in   <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // A register 0 value that points at ptr. The command field is random but
  // never a channel reset, so the pointer survives for the next access.
  function automatic logic [7:0] pointer_byte(input logic [2:0] ptr);
    logic [2:0] cmd;
    cmd = 3'($urandom);
    if (cmd == CMD_CHANNEL_RESET) cmd = CMD_STATUS_RESET;
    return {2'($urandom), cmd, ptr};
  endfunction

  // Two-step register write: set the pointer, then write the register.
  task automatic point_and_write(input logic ch, input logic [2:0] ptr, input logic [7:0] data);
    send(OP_CTRL_WRITE, ch, pointer_byte(ptr));
    send(OP_CTRL_WRITE, ch, data);
  endtask

  // Random traffic built mostly from well-formed register sequences, with
  // bursts of receive bytes and data reads so the FIFOs and the interrupt
  // logic stay busy. A tenth of it is unstructured noise.
  task automatic random_traffic(input int count);
    int goal;
    int kind;
    int n;
    logic ch;
    goal = items_sent + count;
    while (items_sent < goal) begin
      ch   = 1'($urandom_range(1));
      kind = $urandom_range(99);
      if (kind < 16) begin
        // Write registers 1 to 7; register 1 enables the interrupts and
        // channel 1 register 2 is the vector.
        point_and_write(ch, 3'($urandom_range(1, 7)), 8'($urandom));
      end else if (kind < 26) begin
        send(OP_CTRL_WRITE, ch, pointer_byte(3'($urandom)));
        send(OP_CTRL_READ, ch, 8'($urandom));
      end else if (kind < 46) begin
        n = $urandom_range(1, 8);
        repeat (n) send(OP_RX_BYTE, ch, 8'($urandom));
      end else if (kind < 62) begin
        n = $urandom_range(1, 6);
        repeat (n) send(OP_DATA_READ, ch, 8'($urandom));
      end else if (kind < 74) begin
        send(OP_DATA_WRITE, ch, 8'($urandom));
      end else if (kind < 90) begin
        // Command through register 0 with the pointer field left at zero.
        send(OP_CTRL_WRITE, ch, {2'($urandom), 3'($urandom), PTR_REG0});
      end else begin
        send(3'($urandom_range(4)), ch, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Phase one: the sender idles less than the receiver.
    send_idle_pct = 38;
    recv_idle_pct = 58;

    // Directed checks. A data read on an empty FIFO returns zero, and the
    // status read right after reset shows tx empty, DCD and CTS.
    send(OP_DATA_READ, 1'b0, 8'h00);
    send(OP_CTRL_READ, 1'b0, 8'hFF);
    // Vector in channel 1 register 2, then every mode bit in channel 0
    // register 1 so both receive and transmit interrupts are armed.
    point_and_write(1'b1, PTR_REG2, 8'hA5);
    point_and_write(1'b0, PTR_REG1, 8'hFF);
    // First byte raises a receive interrupt; the second finds it pending.
    send(OP_RX_BYTE, 1'b0, 8'h00);
    send(OP_RX_BYTE, 1'b0, 8'hFF);
    // Transmit interrupt is raised even though one is pending.
    send(OP_DATA_WRITE, 1'b0, 8'hFF);
    // The read clears pending and the byte left behind raises it again.
    send(OP_DATA_READ, 1'b0, 8'h55);
    send(OP_CTRL_WRITE, 1'b0, {2'b00, CMD_STATUS_RESET, PTR_REG0});
    send(OP_CTRL_WRITE, 1'b1, {2'b11, CMD_TX_PEND_RESET, PTR_REG0});
    send(OP_CTRL_READ, 1'b1, 8'h00);
    // Status reads through pointers above 2, and through 2, return zero.
    send(OP_CTRL_WRITE, 1'b0, {2'b00, 3'b000, 3'd7});
    send(OP_CTRL_READ, 1'b0, 8'h00);
    send(OP_CTRL_WRITE, 1'b1, {2'b00, 3'b000, PTR_REG2});
    send(OP_CTRL_READ, 1'b1, 8'h00);
    point_and_write(1'b1, 3'd7, 8'h80);
    send(OP_DATA_WRITE, 1'b1, 8'h00);
    send(OP_DATA_READ, 1'b0, 8'h00);
    // Channel resets: channel 1 loses the vector, channel 0 its registers.
    send(OP_CTRL_WRITE, 1'b1, {2'b00, CMD_CHANNEL_RESET, PTR_REG0});
    send(OP_DATA_WRITE, 1'b0, 8'h3C);
    send(OP_CTRL_WRITE, 1'b0, {2'b01, CMD_CHANNEL_RESET, PTR_REG0});
    send(OP_CTRL_READ, 1'b0, 8'h00);

    // Fill channel 0 past its depth while the receiver holds off, so the
    // block backs up and the bytes beyond a full FIFO are dropped.
    hold_request = 1'b1;
    repeat (FIFO_DEPTH_DEF + 3) send(OP_RX_BYTE, 1'b0, 8'($urandom));
    repeat (8) send(OP_DATA_READ, 1'b0, 8'($urandom));
    random_traffic(110);

    // Phase two: the receiver idles less than the sender.
    send_idle_pct = 58;
    recv_idle_pct = 38;
    random_traffic(115);

    // Phase three: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(115);

    in_valid <= 1'b0;
    while (responses_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("** dual_serial_channel_registers_core: PASSED **");
    end else begin
      $display("** dual_serial_channel_registers_core: FAILED **");
    end
    $finish;
  end

endmodule
